// ===== hw/rtl/svpwm_pkg.sv =====
`default_nettype none

package svpwm_pkg;

  // Input beat
  typedef struct packed {
    logic signed [15:0] ref_alpha;
    logic signed [15:0] ref_beta;
    logic        [15:0] dc_voltage;
    logic signed [23:0] angular_speed;
  } svpwm_in_t;

  // Result beat
  typedef struct packed {
    logic        [15:0] duty_a;
    logic        [15:0] duty_b;
    logic        [15:0] duty_c;
    logic signed [15:0] limited_alpha;
    logic signed [15:0] limited_beta;
    logic               dc_invalid;
  } svpwm_out_t;

  // Config register map
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_COMP_GAIN     = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 8'd1;
  localparam logic [15:0] COMP_GAIN_RST     = 16'd24576;
  localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd100000;

  // Arithmetic constants
  localparam logic [31:0] PHASE_K       = 32'd2935890503;
  localparam int          XW            = 34;
  localparam int          ZW            = 34;
  localparam logic signed [XW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam int          CORDIC_STEPS  = 16;
  localparam logic signed [35:0] SQRT3_Q14 = 36'sd28378;
  localparam logic [29:0] INV_SQRT3_Q30 = 30'd619925131;
  localparam logic [17:0] DIV3_RECIP    = 18'd174763;
  localparam int          DIV_BITS      = 17;
  localparam int          DIV_NW        = 51;
  localparam int          DIV_DW        = 34;

  // Pipeline depth and positions of a few stages in the valid chain
  localparam int NSTAGE     = 50;
  localparam int VLD_CORDIC = 21;
  localparam int VLD_DIV    = 45;

  // CORDIC arctangent table, 2^-32 turns
  function automatic logic signed [ZW-1:0] cordic_atan(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:  r = 34'sd536870912;
      4'd1:  r = 34'sd316933406;
      4'd2:  r = 34'sd167458907;
      4'd3:  r = 34'sd85004756;
      4'd4:  r = 34'sd42667331;
      4'd5:  r = 34'sd21354465;
      4'd6:  r = 34'sd10679838;
      4'd7:  r = 34'sd5340245;
      4'd8:  r = 34'sd2670163;
      4'd9:  r = 34'sd1335087;
      4'd10: r = 34'sd667544;
      4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;
      4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41721;
      4'd15: r = 34'sd20860;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Symmetric rounding of n / 2^30
  function automatic logic signed [17:0] round_q30(input logic signed [49:0] n);
    logic [49:0] m;
    logic [19:0] q;
    m = n[49] ? 50'(-n) : 50'(n);
    q = 20'((m + 50'd536870912) >> 30);
    return n[49] ? -18'(q) : 18'(q);
  endfunction

  // Saturate to 16 bit signed
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/svpwm_duty_ratio_generator_unit.sv =====
// Throughput: one beat per cycle while a valid output is not stalled; every
// stage is a register, including the 16-stage CORDIC and the 17-stage
// restoring divider with one lane per phase.
// A stalled output freezes the whole pipeline; no beat is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads comp_gain = 1.5 and
// sample_period = 100000 ns.
`default_nettype none

module svpwm_duty_ratio_generator_unit
  import svpwm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire svpwm_in_t          in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output svpwm_out_t              out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [23:0]        cfg_data
);

  logic              en;
  logic [NSTAGE-1:0] vld;
  logic [15:0]       comp_gain;
  logic [23:0]       sample_period;

  assign en        = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTAGE-1];
  assign cfg_ready = 1'b1;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_gain     <= COMP_GAIN_RST;
      sample_period <= SAMPLE_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COMP_GAIN:     comp_gain     <= cfg_data[15:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // ---------------- Delay phase ----------------
  logic signed [15:0] s_a [1:5];
  logic signed [15:0] s_b [1:5];
  logic        [15:0] s_dc [1:5];
  logic               s_neg [1:4];
  logic [39:0] s1_gp;
  logic [23:0] s1_wabs;
  logic [43:0] s2_mlo, s2_mhi;
  logic [62:0] s3_mag;
  logic [63:0] s4_pl;
  logic [62:0] s4_ph;
  logic [95:0] psum;
  logic [31:0] s5_phase;

  assign psum = 96'(s4_pl) + {1'b0, s4_ph, 32'b0} + (96'(1) << 51);

  always_ff @(posedge clk) begin
    if (en) begin
      // gain times period, speed magnitude
      s_a[1]  <= in_data.ref_alpha;
      s_b[1]  <= in_data.ref_beta;
      s_dc[1] <= in_data.dc_voltage;
      s_neg[1] <= in_data.angular_speed[23];
      s1_wabs <= in_data.angular_speed[23] ? 24'(-in_data.angular_speed)
                                           : 24'(in_data.angular_speed);
      s1_gp   <= 40'(comp_gain) * 40'(sample_period);
      // partial products of the 63-bit magnitude
      s_a[2] <= s_a[1]; s_b[2] <= s_b[1]; s_dc[2] <= s_dc[1]; s_neg[2] <= s_neg[1];
      s2_mlo  <= 44'(s1_gp[19:0]) * 44'(s1_wabs);
      s2_mhi  <= 44'(s1_gp[39:20]) * 44'(s1_wabs);
      // magnitude
      s_a[3] <= s_a[2]; s_b[3] <= s_b[2]; s_dc[3] <= s_dc[2]; s_neg[3] <= s_neg[2];
      s3_mag <= 63'(s2_mlo) + {s2_mhi[42:0], 20'b0};
      // scale to turns
      s_a[4] <= s_a[3]; s_b[4] <= s_b[3]; s_dc[4] <= s_dc[3]; s_neg[4] <= s_neg[3];
      s4_pl  <= 64'(s3_mag[31:0]) * 64'(PHASE_K);
      s4_ph  <= 63'(s3_mag[62:32]) * 63'(PHASE_K);
      // round and apply sign
      s_a[5] <= s_a[4]; s_b[5] <= s_b[4]; s_dc[5] <= s_dc[4];
      s5_phase <= s_neg[4] ? -psum[83:52] : psum[83:52];
    end
  end

  // ---------------- CORDIC ----------------
  logic signed [XW-1:0] c_x [0:CORDIC_STEPS];
  logic signed [XW-1:0] c_y [0:CORDIC_STEPS];
  logic signed [ZW-1:0] c_z [0:CORDIC_STEPS];
  logic signed [15:0]   c_a [0:CORDIC_STEPS];
  logic signed [15:0]   c_b [0:CORDIC_STEPS];
  logic        [15:0]   c_dc [0:CORDIC_STEPS];
  logic        [31:0]   pf, pz;

  assign pf = s5_phase + 32'h4000_0000;
  assign pz = pf[31] ? s5_phase + 32'h8000_0000 : s5_phase;

  // fold left half plane
  always_ff @(posedge clk) begin
    if (en) begin
      c_x[0]  <= pf[31] ? -CORDIC_INV_GAIN : CORDIC_INV_GAIN;
      c_y[0]  <= '0;
      c_z[0]  <= {{(ZW-32){pz[31]}}, pz};
      c_a[0]  <= s_a[5];
      c_b[0]  <= s_b[5];
      c_dc[0] <= s_dc[5];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = c_x[i] >>> i;
    assign ys = c_y[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!c_z[i][ZW-1]) begin
          c_x[i+1] <= c_x[i] - ys;
          c_y[i+1] <= c_y[i] + xs;
          c_z[i+1] <= c_z[i] - cordic_atan(4'(i));
        end else begin
          c_x[i+1] <= c_x[i] + ys;
          c_y[i+1] <= c_y[i] - xs;
          c_z[i+1] <= c_z[i] + cordic_atan(4'(i));
        end
        c_a[i+1]  <= c_a[i];
        c_b[i+1]  <= c_b[i];
        c_dc[i+1] <= c_dc[i];
      end
    end
  end

  // ---------------- Rotation and phases ----------------
  logic signed [49:0] r1_ac, r1_bs, r1_as, r1_bc;
  logic signed [17:0] r2_ra, r2_rb;
  logic signed [35:0] p1_ra14, p1_t, p1_u0;
  logic signed [35:0] p2_u [0:2];
  logic signed [35:0] p3_u [0:2];
  logic signed [35:0] p3_mx, p3_mn;
  logic signed [37:0] p4_v [0:2];
  logic signed [37:0] p4_vm;
  logic        [15:0] r_dc [1:2];
  logic        [15:0] p_dc [1:4];
  logic signed [35:0] mx_next, mn_next;

  always_comb begin
    mx_next = p2_u[0];
    mn_next = p2_u[0];
    for (int k = 1; k < 3; k++) begin
      if (p2_u[k] > mx_next) mx_next = p2_u[k];
      if (p2_u[k] < mn_next) mn_next = p2_u[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      r_dc[1] <= c_dc[CORDIC_STEPS];
      r1_ac <= 50'(c_a[CORDIC_STEPS]) * 50'(c_x[CORDIC_STEPS]);
      r1_bs <= 50'(c_b[CORDIC_STEPS]) * 50'(c_y[CORDIC_STEPS]);
      r1_as <= 50'(c_a[CORDIC_STEPS]) * 50'(c_y[CORDIC_STEPS]);
      r1_bc <= 50'(c_b[CORDIC_STEPS]) * 50'(c_x[CORDIC_STEPS]);
      // rotated reference
      r_dc[2] <= r_dc[1];
      r2_ra <= round_q30(r1_ac - r1_bs);
      r2_rb <= round_q30(r1_as + r1_bc);
      // sqrt(3) term
      p_dc[1] <= r_dc[2];
      p1_ra14 <= 36'(r2_ra) <<< 14;
      p1_u0   <= 36'(r2_ra) <<< 15;
      p1_t    <= 36'(r2_rb) * SQRT3_Q14;
      // phase voltages
      p_dc[2] <= p_dc[1];
      p2_u[0] <= p1_u0;
      p2_u[1] <= p1_t - p1_ra14;
      p2_u[2] <= -p1_ra14 - p1_t;
      // extremes
      p_dc[3] <= p_dc[2];
      p3_u    <= p2_u;
      p3_mx   <= mx_next;
      p3_mn   <= mn_next;
      // zero sequence removed
      p_dc[4] <= p_dc[3];
      for (int k = 0; k < 3; k++) begin
        p4_v[k] <= (38'(p3_u[k]) <<< 1) - (38'(p3_mx) + 38'(p3_mn));
      end
      p4_vm <= 38'(p3_mx) - 38'(p3_mn);
    end
  end

  // ---------------- Divider setup ----------------
  logic [DIV_NW-1:0]   dv_r [0:DIV_BITS][0:2];
  logic [DIV_BITS-1:0] dv_q [0:DIV_BITS][0:2];
  logic                dv_z [0:DIV_BITS][0:2];
  logic [DIV_DW-1:0]   dv_d [0:DIV_BITS];
  logic [15:0]         dv_dc [0:DIV_BITS];

  logic signed [37:0] dc_sh, vsum, num;
  logic               om;
  logic [DIV_DW-1:0]  d_next;
  logic [DIV_NW-1:0]  n_next [0:2];
  logic               z_next [0:2];

  assign dc_sh  = 38'({p_dc[4], 15'b0});
  assign om     = p4_vm > dc_sh;
  assign d_next = om ? p4_vm[DIV_DW-1:0] : DIV_DW'(p_dc[4]);

  always_comb begin
    vsum = '0;
    num  = '0;
    for (int k = 0; k < 3; k++) begin
      vsum = p4_v[k] + p4_vm;
      num  = p4_v[k] + dc_sh;
      z_next[k] = !om && (num <= 38'sd0);
      if (om) begin
        n_next[k] = (DIV_NW'(vsum[33:0]) << 15) + DIV_NW'(d_next >> 1);
      end else if (z_next[k]) begin
        n_next[k] = '0;
      end else begin
        n_next[k] = DIV_NW'(num[36:0]) + DIV_NW'(d_next >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[0]  <= d_next;
      dv_dc[0] <= p_dc[4];
      for (int k = 0; k < 3; k++) begin
        dv_r[0][k] <= n_next[k];
        dv_q[0][k] <= '0;
        dv_z[0][k] <= z_next[k];
      end
    end
  end

  // ---------------- Restoring divider, one quotient bit a stage ----------------
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    logic [DIV_NW-1:0] dsh;
    assign dsh = DIV_NW'(dv_d[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_d[j+1]  <= dv_d[j];
        dv_dc[j+1] <= dv_dc[j];
        for (int k = 0; k < 3; k++) begin
          dv_z[j+1][k] <= dv_z[j][k];
          if (dv_r[j][k] >= dsh) begin
            dv_r[j+1][k] <= dv_r[j][k] - dsh;
            dv_q[j+1][k] <= dv_q[j][k] | (DIV_BITS'(1) << B);
          end else begin
            dv_r[j+1][k] <= dv_r[j][k];
            dv_q[j+1][k] <= dv_q[j][k];
          end
        end
      end
    end
  end

  // ---------------- Duties and realized voltage ----------------
  logic [15:0] q_d [0:2];
  logic [15:0] e1_d [0:2];
  logic [15:0] e2_d [0:2];
  logic [15:0] q_dc, e1_dc, e2_dc;
  logic signed [18:0] e_sum;
  logic signed [17:0] f_dif;
  logic signed [35:0] e1_na;
  logic signed [34:0] e1_nb;
  logic [34:0] ma;
  logic [31:0] mb;
  logic [17:0] xa;
  logic [35:0] e2_pa;
  logic [61:0] e2_pb;
  logic        e2_sa, e2_sb;
  logic [16:0] qa, qb;
  logic signed [17:0] al, be;

  assign e_sum = $signed({2'b0, q_d[0], 1'b0}) - $signed({3'b0, q_d[1]})
               - $signed({3'b0, q_d[2]});
  assign f_dif = $signed({2'b0, q_d[1]}) - $signed({2'b0, q_d[2]});
  assign ma    = e1_na[35] ? 35'(-e1_na) : 35'(e1_na);
  assign mb    = e1_nb[34] ? 32'(-e1_nb) : 32'(e1_nb);
  assign xa    = 18'((ma + 35'd98304) >> 16);
  assign qa    = 17'(e2_pa >> 19);
  assign qb    = 17'((e2_pb + (62'(1) << 45)) >> 46);
  assign al    = e2_sa ? -18'(qa) : 18'(qa);
  assign be    = e2_sb ? -18'(qb) : 18'(qb);

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp quotients
      q_dc <= dv_dc[DIV_BITS];
      for (int k = 0; k < 3; k++) begin
        if (dv_z[DIV_BITS][k]) begin
          q_d[k] <= '0;
        end else if (dv_q[DIV_BITS][k][DIV_BITS-1]) begin
          q_d[k] <= 16'hFFFF;
        end else begin
          q_d[k] <= dv_q[DIV_BITS][k][15:0];
        end
      end
      // duty combinations times DC voltage
      e1_d  <= q_d;
      e1_dc <= q_dc;
      e1_na <= 36'(e_sum) * 36'({1'b0, q_dc});
      e1_nb <= 35'(f_dif) * 35'({1'b0, q_dc});
      // constant scaling
      e2_d  <= e1_d;
      e2_dc <= e1_dc;
      e2_sa <= e1_na[35];
      e2_sb <= e1_nb[34];
      e2_pa <= 36'(xa) * 36'(DIV3_RECIP);
      e2_pb <= 62'(mb) * 62'(INV_SQRT3_Q30);
      // output register
      if (e2_dc == 16'd0) begin
        out_data.duty_a        <= 16'd32768;
        out_data.duty_b        <= 16'd32768;
        out_data.duty_c        <= 16'd32768;
        out_data.limited_alpha <= '0;
        out_data.limited_beta  <= '0;
        out_data.dc_invalid    <= 1'b1;
      end else begin
        out_data.duty_a        <= e2_d[0];
        out_data.duty_b        <= e2_d[1];
        out_data.duty_c        <= e2_d[2];
        out_data.limited_alpha <= sat16(al);
        out_data.limited_beta  <= sat16(be);
        out_data.dc_invalid    <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // defaulted beat when DC voltage is zero
  a_dc_default: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dc_invalid |-> out_data.duty_a == 16'd32768 &&
      out_data.duty_b == 16'd32768 && out_data.duty_c == 16'd32768 &&
      out_data.limited_alpha == 16'sd0 && out_data.limited_beta == 16'sd0)
    else $error("dc_invalid beat not defaulted");

  // a stall freezes the valid chain
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  // CORDIC residual angle converged
  a_cordic_conv: assert property (@(posedge clk) disable iff (rst)
    vld[VLD_CORDIC] |-> c_z[CORDIC_STEPS] < 34'sd65536 &&
      c_z[CORDIC_STEPS] > -34'sd65536)
    else $error("CORDIC did not converge");

  // lane 0 quotient never exceeds one full scale; zeroed lanes carry no quotient
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    vld[VLD_DIV] && !dv_z[DIV_BITS][0] && dv_q[DIV_BITS][0][DIV_BITS-1] |->
      dv_q[DIV_BITS][0][15:0] == 16'd0)
    else $error("divider quotient out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import svpwm_pkg::*;

  // Duty-ratio mirror and result ledger
  class duty_ledger;
    longint unsigned gain = 24576;
    longint unsigned period = 100000;
    svpwm_out_t exp_q[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function longint rdiv(longint n, longint d);
      longint m, q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
    endfunction

    function longint clip16(longint v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function svpwm_out_t predict(svpwm_in_t it);
      longint a, b, dcv, w, c, s, ra, rb, mx, mn, vm, q, num, al, be, x, y, z, xs, ys;
      longint u[3], v[3], d[3];
      longint unsigned mag, lo, hi, t, carry, mid;
      logic [31:0] p;
      longint atan_t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                             21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                             333772, 166886, 83443, 41721, 20860};
      svpwm_out_t r;
      a = longint'($signed(it.ref_alpha));
      b = longint'($signed(it.ref_beta));
      dcv = longint'({48'd0, it.dc_voltage});
      w = longint'($signed(it.angular_speed));
      if (dcv == 0) begin
        r = '0;
        r.duty_a = 16'd32768;
        r.duty_b = 16'd32768;
        r.duty_c = 16'd32768;
        r.dc_invalid = 1'b1;
        return r;
      end
      // Delay compensation phase, 2^-32 turns, 64-bit wrap as in hardware
      mag = gain * period * longint'((w < 0) ? -w : w);
      lo = (mag & 64'hFFFF_FFFF) * 64'd2935890503;
      hi = (mag >> 32) * 64'd2935890503;
      t = lo + (64'd1 << 51);
      carry = (t < lo) ? (64'd1 << 32) : 64'd0;
      mid = hi + (t >> 32) + carry;
      p = mid[51:20];
      if (w < 0) p = -p;
      // CORDIC, left half plane folded by half a turn
      x = 652032874;
      y = 0;
      if (((p + 32'h4000_0000) & 32'h8000_0000) != 0) begin
        x = -x;
        p = p + 32'h8000_0000;
      end
      z = longint'($signed(p));
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_t[i];
        end else begin
          x += ys; y -= xs; z += atan_t[i];
        end
      end
      c = x;
      s = y;
      ra = rdiv(a * c - b * s, 64'd1 << 30);
      rb = rdiv(a * s + b * c, 64'd1 << 30);
      // Three phases and min-max zero sequence
      u[0] = 2 * ra * 16384;
      u[1] = -ra * 16384 + 28378 * rb;
      u[2] = -ra * 16384 - 28378 * rb;
      mx = u[0]; mn = u[0];
      for (int k = 1; k < 3; k++) begin
        if (u[k] > mx) mx = u[k];
        if (u[k] < mn) mn = u[k];
      end
      vm = 0;
      for (int k = 0; k < 3; k++) begin
        v[k] = 2 * u[k] - (mx + mn);
        if (k == 0 || v[k] > vm) vm = v[k];
      end
      // Duties, with common scaling on overmodulation
      for (int k = 0; k < 3; k++) begin
        if (vm > dcv * 32768) begin
          q = rdiv(32768 * (v[k] + vm), vm);
        end else begin
          num = v[k] + 32768 * dcv;
          q = (num <= 0) ? 0 : rdiv(num, dcv);
        end
        if (q < 0) q = 0;
        if (q > 65535) q = 65535;
        d[k] = q;
      end
      al = rdiv((2 * d[0] - d[1] - d[2]) * dcv, 196608);
      be = rdiv((d[1] - d[2]) * dcv * 619925131, 64'd1 << 46);
      r.duty_a = 16'(d[0]);
      r.duty_b = 16'(d[1]);
      r.duty_c = 16'(d[2]);
      r.limited_alpha = 16'(clip16(al));
      r.limited_beta = 16'(clip16(be));
      r.dc_invalid = 1'b0;
      return r;
    endfunction

    function void note_input(svpwm_in_t it);
      exp_q.push_back(predict(it));
    endfunction

    task check_result(svpwm_out_t got);
      svpwm_out_t e;
      if (exp_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = exp_q.pop_front();
      if (got.duty_a !== e.duty_a)
        report($sformatf("duty_a got %0d exp %0d", got.duty_a, e.duty_a));
      if (got.duty_b !== e.duty_b)
        report($sformatf("duty_b got %0d exp %0d", got.duty_b, e.duty_b));
      if (got.duty_c !== e.duty_c)
        report($sformatf("duty_c got %0d exp %0d", got.duty_c, e.duty_c));
      if (got.limited_alpha !== e.limited_alpha)
        report($sformatf("limited_alpha got %0d exp %0d",
                         got.limited_alpha, e.limited_alpha));
      if (got.limited_beta !== e.limited_beta)
        report($sformatf("limited_beta got %0d exp %0d",
                         got.limited_beta, e.limited_beta));
      if (got.dc_invalid !== e.dc_invalid)
        report($sformatf("dc_invalid got %0b exp %0b", got.dc_invalid, e.dc_invalid));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  svpwm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  svpwm_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  duty_ledger sb = new;
  int send_idle = 34;
  int recv_idle = 51;
  int phase_no = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  svpwm_duty_ratio_generator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // Beat monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Receiver: random stalls, one long hold-off in the second phase
  initial begin
    forever begin
      @(negedge clk);
      if (phase_no == 1 && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !rst && ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Drive one input beat; called and returns at a falling edge
  task send_beat(svpwm_in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COMP_GAIN) sb.gain = longint'(val[15:0]);
    else if (idx == REG_SAMPLE_PERIOD) sb.period = longint'(val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task drain;
    in_valid = 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
  endtask

  function svpwm_in_t mk(int a, int b, int dc, int w);
    svpwm_in_t it;
    it.ref_alpha = 16'(a);
    it.ref_beta = 16'(b);
    it.dc_voltage = 16'(dc);
    it.angular_speed = 24'(w);
    return it;
  endfunction

  function svpwm_in_t rand_item();
    int kind, dc, lim;
    kind = $urandom_range(9);
    if (kind == 0)
      return mk($urandom, $urandom, 0, $urandom);
    if (kind <= 2)
      return mk($urandom, $urandom, $urandom, $urandom);
    // Mostly in-range references with realistic speed
    dc = $urandom_range(65535, 1);
    lim = dc * 3 / 4;
    return mk(int'($urandom_range(2 * lim)) - lim, int'($urandom_range(2 * lim)) - lim,
              dc, int'($urandom_range(1024000)) - 512000);
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    // Directed: zero dc, field extremes, overmodulation, tiny values
    send_beat(mk(12345, -777, 0, -8388608));
    send_beat(mk(32767, 0, 65535, 0));
    send_beat(mk(-32768, -32768, 65535, 0));
    send_beat(mk(32767, 32767, 1, 8388607));
    send_beat(mk(-32768, 32767, 100, -8388608));
    send_beat(mk(0, 0, 65535, 0));
    send_beat(mk(0, 0, 1, 1));
    send_beat(mk(1000, -500, 8000, 32000));
    send_beat(mk(16, 0, 32, -1));
    send_beat(mk(-1, -1, 65535, -1));
    send_beat(mk(32767, -32768, 65535, 8388607));
    send_beat(mk(4000, 3000, 9000, -32000));
    send_beat(mk(-20000, 15000, 20000, 64000));
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      phase_no = ph;
      send_idle = (ph < 2) ? 34 : ((ph < 4) ? 51 : 0);
      recv_idle = (ph < 2) ? 51 : ((ph < 4) ? 34 : 0);
      case (ph)
        1: begin
          write_reg(REG_COMP_GAIN, 24'd0);
          write_reg(REG_SAMPLE_PERIOD, 24'd1);
        end
        2: begin
          write_reg(REG_COMP_GAIN, 24'd65535);
          write_reg(REG_SAMPLE_PERIOD, 24'd10000000);
        end
        3: begin
          write_reg(8'd2, 24'hABCDEF);
          write_reg(REG_COMP_GAIN, 24'($urandom_range(65535)));
          write_reg(REG_SAMPLE_PERIOD, 24'd0);
        end
        4: begin
          write_reg(REG_COMP_GAIN, 24'($urandom));
          write_reg(REG_SAMPLE_PERIOD, 24'($urandom));
        end
        5: begin
          write_reg(REG_COMP_GAIN, 24'hFFFFFF);
          write_reg(REG_SAMPLE_PERIOD, 24'hFFFFFF);
        end
        default: ;
      endcase
      repeat (323) send_beat(rand_item());
    end
    in_valid = 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (sb.exp_q.size() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_duty_ratio_generator_unit.sv
verif/tb.sv
